@@ rtl/core/faa_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, payload types and divider helpers for the frame averaging block.
package faa_pkg;

    localparam int unsigned MAX_PIXELS = 65536;
    localparam int unsigned MAX_FRAMES = 256;
    localparam int unsigned PIX_AW     = $clog2(MAX_PIXELS);
    localparam int unsigned FRM_W      = $clog2(MAX_FRAMES);
    localparam int unsigned PPF_W      = PIX_AW + 1;
    localparam int unsigned NFR_W      = FRM_W + 1;
    localparam int unsigned CFG_W      = PPF_W;
    localparam int unsigned CH_W       = 8;
    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned ACC_W      = SUM_W + 1;
    localparam int unsigned DIV_STAGES = CH_W / 2;

    typedef enum logic [0:0] {
        CFG_PIXELS_PER_FRAME  = 1'b0,
        CFG_FRAMES_TO_AVERAGE = 1'b1
    } faa_cfg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } faa_pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_avg;
        logic [CH_W-1:0] green_avg;
        logic [CH_W-1:0] blue_avg;
        logic            image_end;
    } faa_pix_out_t;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] faa_sums_t;

    typedef struct packed {
        logic [NUM_CH-1:0][ACC_W-1:0] rem;
        logic [NUM_CH-1:0][CH_W-1:0]  quo;
        logic [NUM_CH-1:0]            ovf;
        logic [NFR_W-1:0]             divisor;
        logic                         image_end;
    } faa_div_t;

    function automatic logic [ACC_W:0] div_step(input logic [ACC_W-1:0] rem,
                                                input logic [ACC_W-1:0] dsh);
        logic ge;
        ge = (rem >= dsh);
        return {ge, (ge ? (rem - dsh) : rem)};
    endfunction

endpackage

@@ rtl/core/faa_store.sv @@
`timescale 1ns / 1ps
// Per-pixel channel sum memory with one write port and one registered read port.
module faa_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [faa_pkg::PIX_AW-1:0]  wr_addr,
    input  faa_pkg::faa_sums_t          wr_data,
    input  logic                        rd_en,
    input  logic [faa_pkg::PIX_AW-1:0]  rd_addr,
    output faa_pkg::faa_sums_t          rd_data
);

    faa_pkg::faa_sums_t mem [faa_pkg::MAX_PIXELS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/faa_divider.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, two quotient bits per stage, three channels with saturation.
module faa_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  faa_pkg::faa_div_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output faa_pkg::faa_pix_out_t out_data
);

    localparam int unsigned LAST = faa_pkg::DIV_STAGES - 1;

    faa_pkg::faa_div_t                st_reg [faa_pkg::DIV_STAGES];
    logic [faa_pkg::DIV_STAGES-1:0]   v_reg;
    logic [faa_pkg::DIV_STAGES:0]     free_w;
    logic [faa_pkg::DIV_STAGES-1:0]   v_src;

    assign free_w[faa_pkg::DIV_STAGES] = out_ready;
    assign in_ready = free_w[0];

    genvar k;
    generate
        for (k = 0; k < faa_pkg::DIV_STAGES; k++)
        begin : g_stage
            localparam int unsigned HI = faa_pkg::CH_W - 1 - 2 * k;
            localparam int unsigned LO = HI - 1;

            faa_pkg::faa_div_t       src;
            faa_pkg::faa_div_t       st_next;
            logic [faa_pkg::ACC_W-1:0] d_hi;
            logic [faa_pkg::ACC_W-1:0] d_lo;
            logic [faa_pkg::ACC_W:0]   s_hi [faa_pkg::NUM_CH];
            logic [faa_pkg::ACC_W:0]   s_lo [faa_pkg::NUM_CH];

            if (k == 0)
            begin : g_first
                assign src      = in_data;
                assign v_src[k] = in_valid;
            end
            else
            begin : g_next
                assign src      = st_reg[k-1];
                assign v_src[k] = v_reg[k-1];
            end

            assign free_w[k] = !v_reg[k] || free_w[k+1];

            always_comb
            begin
                d_hi    = faa_pkg::ACC_W'(src.divisor) << HI;
                d_lo    = faa_pkg::ACC_W'(src.divisor) << LO;
                st_next = src;
                for (int c = 0; c < faa_pkg::NUM_CH; c++)
                begin
                    s_hi[c] = faa_pkg::div_step(src.rem[c], d_hi);
                    s_lo[c] = faa_pkg::div_step(s_hi[c][faa_pkg::ACC_W-1:0], d_lo);
                    st_next.rem[c]     = s_lo[c][faa_pkg::ACC_W-1:0];
                    st_next.quo[c][HI] = s_hi[c][faa_pkg::ACC_W];
                    st_next.quo[c][LO] = s_lo[c][faa_pkg::ACC_W];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (free_w[k])
                begin
                    v_reg[k] <= v_src[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (free_w[k] && v_src[k])
                begin
                    st_reg[k] <= st_next;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[LAST];

    always_comb
    begin
        out_data.red_avg   = st_reg[LAST].ovf[0] ? '1 : st_reg[LAST].quo[0];
        out_data.green_avg = st_reg[LAST].ovf[1] ? '1 : st_reg[LAST].quo[1];
        out_data.blue_avg  = st_reg[LAST].ovf[2] ? '1 : st_reg[LAST].quo[2];
        out_data.image_end = st_reg[LAST].image_end;
    end

    a_first_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] |-> st_reg[0].divisor != '0)
        else $error("divider stage holds a zero divisor");

    a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (st_reg[LAST].ovf[0] || st_reg[LAST].rem[0] < faa_pkg::ACC_W'(st_reg[LAST].divisor))
         && (st_reg[LAST].ovf[1] || st_reg[LAST].rem[1] < faa_pkg::ACC_W'(st_reg[LAST].divisor))
         && (st_reg[LAST].ovf[2] || st_reg[LAST].rem[2] < faa_pkg::ACC_W'(st_reg[LAST].divisor)))
        else $error("final remainder not below divisor");

    a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("stalled result dropped");

endmodule

@@ rtl/core/frame_average_accumulator.sv @@
`timescale 1ns / 1ps
// Top level: pixel and frame counters, sum store update with bypass, and result pipeline.
// Takes one RGB888 pixel per clock in raster order and returns nothing until the last
// frame of an exposure, when each pixel yields its truncated average once it has passed
// the registered store read and sum stage and the two-bit-per-stage divider pipeline;
// back-to-back hits on one store entry are forwarded, so the rate holds at one pixel
// per clock for any frame size. Output stalls back up through the pipeline.
// After reset the block clears its 65536-entry sum memory, one entry per clock, and
// holds in_ready low until the clear ends; configuration writes are taken throughout.
module frame_average_accumulator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  faa_pkg::faa_pix_in_t          in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output faa_pkg::faa_pix_out_t         out_data,
    input  logic                          cfg_write,
    input  faa_pkg::faa_cfg_idx_t         cfg_index,
    input  logic [faa_pkg::CFG_W-1:0]     cfg_data
);

    logic [faa_pkg::PPF_W-1:0]  ppf_reg;
    logic [faa_pkg::NFR_W-1:0]  nfr_reg;
    logic [faa_pkg::PPF_W-1:0]  ppf_c;
    logic [faa_pkg::NFR_W-1:0]  nfr_c;

    logic [faa_pkg::PIX_AW-1:0] pos_reg;
    logic [faa_pkg::FRM_W-1:0]  frame_reg;
    logic                       last_pix;
    logic                       last_frame;
    logic [faa_pkg::NFR_W-1:0]  divisor;
    logic                       in_fire;

    logic                       clr_active_reg;
    logic [faa_pkg::PIX_AW-1:0] clr_addr_reg;

    logic                       s1_valid_reg;
    logic [faa_pkg::PIX_AW-1:0] s1_pos_reg;
    faa_pkg::faa_pix_in_t       s1_pix_reg;
    logic                       s1_last_frame_reg;
    logic                       s1_last_pix_reg;
    logic [faa_pkg::NFR_W-1:0]  s1_div_reg;
    logic                       byp_reg;
    faa_pkg::faa_sums_t         byp_data_reg;
    logic                       byp_next;
    logic                       s1_go;

    faa_pkg::faa_sums_t         rd_data;
    faa_pkg::faa_sums_t         old_sums;
    faa_pkg::faa_sums_t         wb_data;
    logic [faa_pkg::NUM_CH-1:0][faa_pkg::CH_W-1:0]  vals;
    logic [faa_pkg::NUM_CH-1:0][faa_pkg::ACC_W-1:0] acc;

    logic                       st_wr_en;
    logic [faa_pkg::PIX_AW-1:0] st_wr_addr;
    faa_pkg::faa_sums_t         st_wr_data;

    logic                       div_in_valid;
    logic                       div_in_ready;
    faa_pkg::faa_div_t          div_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppf_reg <= faa_pkg::PPF_W'(faa_pkg::MAX_PIXELS);
            nfr_reg <= faa_pkg::NFR_W'(16);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                faa_pkg::CFG_PIXELS_PER_FRAME:  ppf_reg <= cfg_data;
                faa_pkg::CFG_FRAMES_TO_AVERAGE: nfr_reg <= cfg_data[faa_pkg::NFR_W-1:0];
                default:                        ppf_reg <= ppf_reg;
            endcase
        end
    end

    always_comb
    begin
        if (ppf_reg == '0)
        begin
            ppf_c = faa_pkg::PPF_W'(1);
        end
        else if (ppf_reg > faa_pkg::PPF_W'(faa_pkg::MAX_PIXELS))
        begin
            ppf_c = faa_pkg::PPF_W'(faa_pkg::MAX_PIXELS);
        end
        else
        begin
            ppf_c = ppf_reg;
        end

        if (nfr_reg == '0)
        begin
            nfr_c = faa_pkg::NFR_W'(1);
        end
        else if (nfr_reg > faa_pkg::NFR_W'(faa_pkg::MAX_FRAMES))
        begin
            nfr_c = faa_pkg::NFR_W'(faa_pkg::MAX_FRAMES);
        end
        else
        begin
            nfr_c = nfr_reg;
        end
    end

    assign divisor    = faa_pkg::NFR_W'(frame_reg) + faa_pkg::NFR_W'(1);
    assign last_pix   = (faa_pkg::PPF_W'(pos_reg) + faa_pkg::PPF_W'(1)) >= ppf_c;
    assign last_frame = divisor >= nfr_c;

    assign s1_go    = s1_valid_reg && (!s1_last_frame_reg || div_in_ready);
    assign in_ready = !clr_active_reg && (!s1_valid_reg || s1_go);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            frame_reg <= '0;
        end
        else if (in_fire)
        begin
            if (last_pix)
            begin
                pos_reg   <= '0;
                frame_reg <= last_frame ? '0 : frame_reg + faa_pkg::FRM_W'(1);
            end
            else
            begin
                pos_reg <= pos_reg + faa_pkg::PIX_AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + faa_pkg::PIX_AW'(1);
            if (clr_addr_reg == '1)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        vals[0]  = s1_pix_reg.red_in;
        vals[1]  = s1_pix_reg.green_in;
        vals[2]  = s1_pix_reg.blue_in;
        old_sums = byp_reg ? byp_data_reg : rd_data;
        div_in   = '0;
        for (int c = 0; c < faa_pkg::NUM_CH; c++)
        begin
            acc[c]        = faa_pkg::ACC_W'(old_sums[c]) + faa_pkg::ACC_W'(vals[c]);
            wb_data[c]    = s1_last_frame_reg ? '0 : acc[c][faa_pkg::SUM_W-1:0];
            div_in.rem[c] = acc[c];
            div_in.ovf[c] = acc[c] >= faa_pkg::ACC_W'({s1_div_reg, faa_pkg::CH_W'(0)});
        end
        div_in.divisor   = s1_div_reg;
        div_in.image_end = s1_last_pix_reg;
    end

    assign div_in_valid = s1_valid_reg && s1_last_frame_reg;
    assign byp_next     = s1_go && (s1_pos_reg == pos_reg);

    assign st_wr_en   = clr_active_reg || s1_go;
    assign st_wr_addr = clr_active_reg ? clr_addr_reg : s1_pos_reg;
    assign st_wr_data = clr_active_reg ? '0 : wb_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
            if (in_valid)
            begin
                byp_reg <= byp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pos_reg        <= pos_reg;
            s1_pix_reg        <= in_data;
            s1_last_frame_reg <= last_frame;
            s1_last_pix_reg   <= last_pix;
            s1_div_reg        <= divisor;
            byp_data_reg      <= wb_data;
        end
    end

    faa_store u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (in_fire),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    faa_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_in_valid),
        .in_ready  (div_in_ready),
        .in_data   (div_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_no_transfer_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !in_ready)
        else $error("input taken during memory clear");

    a_exposure_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_pix && last_frame |=> pos_reg == '0 && frame_reg == '0)
        else $error("counters did not restart after exposure");

    a_clear_covers_memory: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) |-> $past(clr_addr_reg) == '1)
        else $error("memory clear ended early");

    a_bypass_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && byp_next |-> s1_valid_reg && !clr_active_reg)
        else $error("bypass taken without a pending write");

endmodule
